/* rtl/lacm_pkg.sv */
`default_nettype none
package lacm_pkg;

  localparam int unsigned TRACKED_ENTRIES = 64;
  localparam int unsigned ADDRESS_BITS    = 48;
  localparam int unsigned AGE_W           = 5;

  localparam logic [AGE_W-1:0] AGE_MAX     = 5'd31;
  localparam logic [AGE_W-1:0] ASSOC_RESET = 5'd4;

  typedef logic [ADDRESS_BITS-1:0] addr_t;
  typedef logic [AGE_W-1:0]        age_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic cold;
    age_t prior_age;
    age_t assoc;
  } lacm_cmd_t;

endpackage
`default_nettype wire

/* rtl/lacm_req_if.sv */
`default_nettype none
interface lacm_req_if;
  logic                  valid;
  logic                  ready;
  lacm_pkg::addr_t       access_address;

  modport source (output valid, output access_address, input ready);
  modport sink   (input valid, input access_address, output ready);
endinterface
`default_nettype wire

/* rtl/lacm_rsp_if.sv */
`default_nettype none
interface lacm_rsp_if;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic                  cold_miss;
  logic                  hot_miss;
  lacm_pkg::age_t        prior_age;
  logic                  table_full;

  modport source (output valid, output hit, output cold_miss, output hot_miss,
                  output prior_age, output table_full, input ready);
  modport sink   (input valid, input hit, input cold_miss, input hot_miss,
                  input prior_age, input table_full, output ready);
endinterface
`default_nettype wire

/* rtl/lacm_cell.sv */
`default_nettype none
module lacm_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lacm_pkg::lacm_cmd_t cmd_i,
  input  wire lacm_pkg::addr_t     addr_i,
  input  wire logic                prev_valid_i,
  output logic                     valid_o,
  output lacm_pkg::age_t           age_o,
  output logic                     match_o
);
  import lacm_pkg::*;

  addr_t addr_q;
  logic  valid_q, match_q;
  age_t  age_q;
  logic  take_here, bump;

  // Entries fill in order, so the first free cell sits right after the last valid one
  assign take_here = cmd_i.cold ? (!valid_q && prev_valid_i) : match_q;
  assign bump = valid_q && (age_q != cmd_i.assoc) && (age_q != AGE_MAX) &&
                (cmd_i.cold || (age_q < cmd_i.prior_age));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
      match_q <= 1'b0;
    end else begin
      if (cmd_i.cmp_en) begin
        match_q <= valid_q && (addr_q == addr_i);
      end
      if (cmd_i.upd_en) begin
        if (take_here) begin
          valid_q <= 1'b1;
          age_q   <= '0;
        end else if (bump) begin
          age_q <= age_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en && cmd_i.cold && !valid_q && prev_valid_i) begin
      addr_q <= addr_i;
    end
  end

  assign valid_o = valid_q;
  assign age_o   = age_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

/* rtl/lru_age_cache_model.sv */
// LRU age cache model: a row of TRACKED_ENTRIES cells, each holding one tracked
// address, its valid bit and its age. An access runs through compare, gather and
// update steps: all cells compare the address in parallel, the matching cell's
// age is gathered into the result register, then the cells update their ages
// together unless the table is full. The next address is accepted during the
// update step; a result not yet taken holds the sequence in the gather step.
// Valid bits clear at reset, so no clearing pass is needed. Associativity is written
// by the user through cfg_we_i/cfg_wdata_i while the block is idle (not enforced).
`default_nettype none
module lru_age_cache_model (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire lacm_pkg::age_t cfg_wdata_i,
  lacm_req_if.sink            req_i,
  lacm_rsp_if.source          rsp_o
);
  import lacm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_RED, ST_UPD} state_e;

  state_e    state_q;
  addr_t     addr_q;
  age_t      assoc_q, prior_q;
  logic      cold_q, full_q;
  logic      rsp_valid_q, hit_q, cold_miss_q, hot_miss_q, table_full_q;
  age_t      rsp_age_q;
  lacm_cmd_t cmd;

  logic [TRACKED_ENTRIES-1:0] cell_valid, cell_match;
  age_t                       cell_age [TRACKED_ENTRIES];
  logic                       found;
  age_t                       found_age;
  logic                       accept, rsp_free;

  assign req_i.ready = (state_q == ST_IDLE) || (state_q == ST_UPD);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  assign cmd.cmp_en    = (state_q == ST_CMP);
  assign cmd.upd_en    = (state_q == ST_UPD) && !full_q;
  assign cmd.cold      = cold_q;
  assign cmd.prior_age = prior_q;
  assign cmd.assoc     = assoc_q;

  for (genvar g = 0; g < TRACKED_ENTRIES; g++) begin : g_cell
    lacm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .addr_i       (addr_q),
      .prev_valid_i ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g-1]),
      .valid_o      (cell_valid[g]),
      .age_o        (cell_age[g]),
      .match_o      (cell_match[g])
    );
  end

  // At most one cell matches: gather its age by OR
  always_comb begin
    found     = 1'b0;
    found_age = '0;
    for (int i = 0; i < TRACKED_ENTRIES; i++) begin
      found     = found | cell_match[i];
      found_age = found_age | (cell_age[i] & {AGE_W{cell_match[i]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= req_i.access_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      assoc_q      <= ASSOC_RESET;
      prior_q      <= '0;
      cold_q       <= 1'b0;
      full_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      cold_miss_q  <= 1'b0;
      hot_miss_q   <= 1'b0;
      table_full_q <= 1'b0;
      rsp_age_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        assoc_q <= cfg_wdata_i;
      end
      if ((state_q == ST_RED) && rsp_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= ST_CMP;
        end
        ST_CMP: begin
          state_q <= ST_RED;
        end
        ST_RED: begin
          // hold until the result register frees up
          if (rsp_free) begin
            prior_q      <= found ? found_age : '0;
            cold_q       <= !found && !cell_valid[TRACKED_ENTRIES-1];
            full_q       <= !found && cell_valid[TRACKED_ENTRIES-1];
            hit_q        <= found && (found_age < assoc_q);
            hot_miss_q   <= found && (found_age == assoc_q);
            cold_miss_q  <= !found && !cell_valid[TRACKED_ENTRIES-1];
            table_full_q <= !found && cell_valid[TRACKED_ENTRIES-1];
            rsp_age_q    <= found ? found_age : '0;
            state_q      <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_q <= accept ? ST_CMP : ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.cold_miss  = cold_miss_q;
  assign rsp_o.hot_miss   = hot_miss_q;
  assign rsp_o.prior_age  = rsp_age_q;
  assign rsp_o.table_full = table_full_q;

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_match))
    else $error("more than one cell matches the access");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("valid cells do not form a prefix");

  a_outcome_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> ($countones({hit_q, cold_miss_q, hot_miss_q, table_full_q}) <= 1))
    else $error("more than one outcome flagged");

  a_full_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && full_q) |=> $stable(cell_valid))
    else $error("table state changed on a dropped access");

endmodule
`default_nettype wire
